// ===== rtl/ttce_pkg.sv =====
package ttce_pkg;

  localparam int DefMaxRows = 32;
  localparam int DefMaxCols = 128;

  localparam int ModeW    = 2;
  localparam int CharW    = 8;
  localparam int RowOutW  = 5;
  localparam int ColOutW  = 7;
  localparam int RowsCfgW = 6;
  localparam int ColsCfgW = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [CharW-1:0] ChBackspace = 8'h08;
  localparam logic [CharW-1:0] ChReturn    = 8'h0D;
  localparam logic [CharW-1:0] ChLineFeed  = 8'h0A;
  localparam logic [CharW-1:0] ChSpace     = 8'h20;

  localparam logic [RowsCfgW-1:0] RowsReset  = 6'd32;
  localparam logic [ColsCfgW-1:0] ColsReset  = 8'd128;
  localparam logic [RowsCfgW-1:0] VRowsReset = 6'd24;
  localparam logic [ColsCfgW-1:0] VColsReset = 8'd80;

  typedef enum logic [ModeW-1:0] {
    MODE_PUT,
    MODE_READ,
    MODE_CLEAR,
    MODE_NONE
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS,
    CFG_COLS,
    CFG_VIEW_ROWS,
    CFG_VIEW_COLS
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_FIT,
    S_EXEC,
    S_VIEW,
    S_READ
  } state_e;

  typedef struct packed {
    logic [CharW-1:0]   cell_char;
    logic [RowOutW-1:0] cursor_row;
    logic [ColOutW-1:0] cursor_col;
    logic [RowOutW-1:0] top_row;
    logic [ColOutW-1:0] left_col;
    logic               scrolled;
    logic               view_moved;
  } result_t;

endpackage

// ===== rtl/ttce_ram.sv =====
module ttce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/text_terminal_cursor_engine.sv =====
// Character-cell terminal buffer with cursor and a visible window that follows it.
// Input channel: in_valid_i/in_stall_o carry one transaction with mode_i, char_code_i,
// read_row_i and read_col_i. Output channel: out_valid_o/out_stall_i carry one result
// transaction per input transaction with the cell read, cursor, window origin and flags.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must
// write it only while the block is idle, which the block itself does not enforce. A
// write takes effect at the clock edge where cfg_we_i is high. The cell array lives
// in one RAM with a registered read, and one input transaction is processed at a
// time by a small sequencer. Putting a character runs accept, cursor fit, cell write
// and window update. A line feed or wrap past the last row then adds a blanking pass,
// one RAM write per cell, over the new bottom row. A cell read runs accept, cursor
// fit and a RAM read, mode 3 only accept and cursor fit, and a clear screen accept,
// cursor fit and a blanking pass over the whole RAM. A computed result is held in a
// result register and moves into the output register once the output is free. A
// result waits in the output register while the receiver stalls, and one more result
// may wait behind it before in_stall_o rises. After reset the block runs a blanking
// pass over all MAX_ROWS*MAX_COLS cells (4096 by default) with in_stall_o high;
// configuration writes are taken meanwhile.
module text_terminal_cursor_engine import ttce_pkg::*; #(
  parameter int MAX_ROWS = DefMaxRows,
  parameter int MAX_COLS = DefMaxCols
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ModeW-1:0]    mode_i,
  input  logic [CharW-1:0]    char_code_i,
  input  logic [RowOutW-1:0]  read_row_i,
  input  logic [ColOutW-1:0]  read_col_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CharW-1:0]    cell_char_o,
  output logic [RowOutW-1:0]  cursor_row_o,
  output logic [ColOutW-1:0]  cursor_col_o,
  output logic [RowOutW-1:0]  top_row_o,
  output logic [ColOutW-1:0]  left_col_o,
  output logic                scrolled_o,
  output logic                view_moved_o
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(Depth);

  localparam logic [RW:0]     RowsWrap   = (RW + 1)'(MAX_ROWS);
  localparam logic [AW-1:0]   ColsStride = AW'(MAX_COLS);
  localparam logic [AW-1:0]   LastAddr   = AW'(Depth - 1);
  localparam logic [CW-1:0]   LastCol    = CW'(MAX_COLS - 1);

  function automatic logic [RW-1:0] phys_row(input logic [RW:0] base, input logic [RW:0] off);
    logic [RW:0] sum;
    sum = base + off;
    if (sum >= RowsWrap) begin
      sum = sum - RowsWrap;
    end
    return RW'(sum);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
                                              input logic [CW-1:0] col);
    return AW'(prow) * ColsStride + AW'(col);
  endfunction

  function automatic logic in_view(input logic [RW-1:0] r, input logic [CW-1:0] c,
                                   input logic [RW-1:0] t, input logic [CW-1:0] l,
                                   input logic [NRW-1:0] h, input logic [NCW-1:0] w);
    return (r >= t) && (NRW'(r) < NRW'(t) + h) && (c >= l) && (NCW'(c) < NCW'(l) + w);
  endfunction

  logic [RowsCfgW-1:0] rows_cfg_q, vrows_cfg_q;
  logic [ColsCfgW-1:0] cols_cfg_q, vcols_cfg_q;
  logic [NRW-1:0]      nr, vr, top_lim;
  logic [NCW-1:0]      nc, vc, left_lim;

  state_e              state_q, state_d;
  mode_e               mode_q;
  logic [CharW-1:0]    char_q;
  logic [RowOutW-1:0]  rrow_q;
  logic [ColOutW-1:0]  rcol_q;

  logic [RW-1:0]       row_base_q, row_base_d, cur_row_q, cur_row_d, view_top_q, view_top_d;
  logic [CW-1:0]       cur_col_q, cur_col_d, view_left_q, view_left_d;
  logic [RW-1:0]       old_top_q;
  logic [CW-1:0]       old_left_q;
  logic                was_in_q, was_in_d, scroll_q, scroll_d;
  logic [AW-1:0]       sweep_addr_q, sweep_addr_d, sweep_end_q, sweep_end_d;

  logic [RW-1:0]       fit_row, fit_top, phys_cur, blank_row;
  logic [CW-1:0]       fit_col, fit_left;
  logic [NRW-1:0]      step_row, adj_top;
  logic [NCW-1:0]      step_col, adj_left;
  logic                rd_ok;

  result_t             res_q, res_d, out_q;
  logic                res_wr, res_pend_q, res_move, out_valid_q, in_acc;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [CharW-1:0]    ram_wdata, ram_rdata;

  always_comb begin
    if (rows_cfg_q == '0) begin
      nr = NRW'(1);
    end else if (int'(rows_cfg_q) > MAX_ROWS) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_cfg_q);
    end
    if (cols_cfg_q == '0) begin
      nc = NCW'(1);
    end else if (int'(cols_cfg_q) > MAX_COLS) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_cfg_q);
    end
    if (vrows_cfg_q == '0) begin
      vr = NRW'(1);
    end else if (int'(vrows_cfg_q) > int'(nr)) begin
      vr = nr;
    end else begin
      vr = NRW'(vrows_cfg_q);
    end
    if (vcols_cfg_q == '0) begin
      vc = NCW'(1);
    end else if (int'(vcols_cfg_q) > int'(nc)) begin
      vc = nc;
    end else begin
      vc = NCW'(vcols_cfg_q);
    end
    top_lim  = nr - vr;
    left_lim = nc - vc;
  end

  always_comb begin
    fit_row  = (cur_row_q >= nr) ? RW'(nr - NRW'(1)) : cur_row_q;
    fit_col  = (cur_col_q >= nc) ? CW'(nc - NCW'(1)) : cur_col_q;
    fit_top  = (view_top_q > top_lim) ? RW'(top_lim) : view_top_q;
    fit_left = (view_left_q > left_lim) ? CW'(left_lim) : view_left_q;
  end

  assign phys_cur  = phys_row({1'b0, row_base_q}, {1'b0, cur_row_q});
  assign blank_row = phys_row({1'b0, row_base_q}, (RW + 1)'(nr));
  assign ram_raddr = cell_addr(phys_row({1'b0, row_base_q}, (RW + 1)'(rrow_q)), CW'(rcol_q));
  assign rd_ok     = (int'(rrow_q) < int'(nr)) && (int'(rcol_q) < int'(nc));

  assign res_move   = res_pend_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE) || (res_pend_q && !res_move);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_SWEEP: begin
        if (sweep_addr_q == sweep_end_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_FIT;
        end
      end
      S_FIT: begin
        case (mode_q)
          MODE_PUT:   state_d = S_EXEC;
          MODE_READ:  state_d = S_READ;
          MODE_CLEAR: state_d = S_SWEEP;
          default:    state_d = S_IDLE;
        endcase
      end
      S_EXEC: state_d = S_VIEW;
      S_VIEW: state_d = scroll_q ? S_SWEEP : S_IDLE;
      S_READ: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    row_base_d   = row_base_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    view_top_d   = view_top_q;
    view_left_d  = view_left_q;
    was_in_d     = was_in_q;
    scroll_d     = scroll_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    step_row     = NRW'(cur_row_q);
    step_col     = NCW'(cur_col_q);
    adj_top      = NRW'(view_top_q);
    adj_left     = NCW'(view_left_q);
    res_d        = res_q;
    res_wr       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = sweep_addr_q;
    ram_wdata    = ChSpace;
    case (state_q)
      S_SWEEP: begin
        ram_we       = 1'b1;
        sweep_addr_d = sweep_addr_q + AW'(1);
      end
      S_FIT: begin
        cur_row_d   = fit_row;
        cur_col_d   = fit_col;
        view_top_d  = fit_top;
        view_left_d = fit_left;
        if (mode_q == MODE_CLEAR) begin
          row_base_d       = '0;
          cur_row_d        = '0;
          cur_col_d        = '0;
          view_top_d       = '0;
          view_left_d      = '0;
          sweep_addr_d     = '0;
          sweep_end_d      = LastAddr;
          res_wr           = 1'b1;
          res_d.cell_char  = '0;
          res_d.cursor_row = '0;
          res_d.cursor_col = '0;
          res_d.top_row    = '0;
          res_d.left_col   = '0;
          res_d.scrolled   = 1'b0;
          res_d.view_moved = (old_top_q != '0) || (old_left_q != '0);
        end else if (mode_q == MODE_NONE) begin
          res_wr           = 1'b1;
          res_d.cell_char  = '0;
          res_d.cursor_row = RowOutW'(fit_row);
          res_d.cursor_col = ColOutW'(fit_col);
          res_d.top_row    = RowOutW'(fit_top);
          res_d.left_col   = ColOutW'(fit_left);
          res_d.scrolled   = 1'b0;
          res_d.view_moved = (fit_top != old_top_q) || (fit_left != old_left_q);
        end
      end
      S_EXEC: begin
        was_in_d  = in_view(cur_row_q, cur_col_q, view_top_q, view_left_q, vr, vc);
        ram_waddr = cell_addr(phys_cur, cur_col_q);
        case (char_q)
          ChBackspace: begin
            if (cur_col_q != '0) begin
              step_col  = NCW'(cur_col_q) - NCW'(1);
              ram_we    = 1'b1;
              ram_wdata = ChSpace;
              ram_waddr = cell_addr(phys_cur, cur_col_q - CW'(1));
            end
          end
          ChReturn: step_col = '0;
          ChLineFeed: step_row = NRW'(cur_row_q) + NRW'(1);
          default: begin
            ram_we    = 1'b1;
            ram_wdata = char_q;
            step_col  = NCW'(cur_col_q) + NCW'(1);
          end
        endcase
        if (step_col == nc) begin
          step_col = '0;
          step_row = step_row + NRW'(1);
        end
        scroll_d  = (step_row == nr);
        cur_col_d = CW'(step_col);
        if (scroll_d) begin
          row_base_d   = phys_row({1'b0, row_base_q}, (RW + 1)'(1));
          cur_row_d    = RW'(nr - NRW'(1));
          sweep_addr_d = cell_addr(blank_row, '0);
          sweep_end_d  = cell_addr(blank_row, LastCol);
        end else begin
          cur_row_d = RW'(step_row);
        end
      end
      S_VIEW: begin
        if (was_in_q && !in_view(cur_row_q, cur_col_q, view_top_q, view_left_q, vr, vc)) begin
          if (cur_row_q < view_top_q) begin
            adj_top = NRW'(cur_row_q);
          end else if (NRW'(cur_row_q) >= NRW'(view_top_q) + vr) begin
            adj_top = NRW'(cur_row_q) + NRW'(1) - vr;
          end
          if (adj_top > top_lim) begin
            adj_top = top_lim;
          end
          if (cur_col_q < view_left_q) begin
            adj_left = NCW'(cur_col_q);
          end else if (NCW'(cur_col_q) >= NCW'(view_left_q) + vc) begin
            adj_left = NCW'(cur_col_q) + NCW'(1) - vc;
          end
          if (adj_left > left_lim) begin
            adj_left = left_lim;
          end
          view_top_d  = RW'(adj_top);
          view_left_d = CW'(adj_left);
        end
        res_wr           = 1'b1;
        res_d.cell_char  = '0;
        res_d.cursor_row = RowOutW'(cur_row_q);
        res_d.cursor_col = ColOutW'(cur_col_q);
        res_d.top_row    = RowOutW'(view_top_d);
        res_d.left_col   = ColOutW'(view_left_d);
        res_d.scrolled   = scroll_q;
        res_d.view_moved = (view_top_d != old_top_q) || (view_left_d != old_left_q);
      end
      S_READ: begin
        res_wr           = 1'b1;
        res_d.cell_char  = rd_ok ? ram_rdata : '0;
        res_d.cursor_row = RowOutW'(cur_row_q);
        res_d.cursor_col = ColOutW'(cur_col_q);
        res_d.top_row    = RowOutW'(view_top_q);
        res_d.left_col   = ColOutW'(view_left_q);
        res_d.scrolled   = 1'b0;
        res_d.view_moved = (view_top_q != old_top_q) || (view_left_q != old_left_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      sweep_addr_q <= '0;
      sweep_end_q  <= LastAddr;
      row_base_q   <= '0;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      view_top_q   <= '0;
      view_left_q  <= '0;
      res_pend_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      rows_cfg_q   <= RowsReset;
      cols_cfg_q   <= ColsReset;
      vrows_cfg_q  <= VRowsReset;
      vcols_cfg_q  <= VColsReset;
    end else begin
      state_q      <= state_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
      row_base_q   <= row_base_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      view_top_q   <= view_top_d;
      view_left_q  <= view_left_d;
      if (res_wr) begin
        res_pend_q <= 1'b1;
      end else if (res_move) begin
        res_pend_q <= 1'b0;
      end
      if (res_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ROWS:      rows_cfg_q  <= cfg_wdata_i[RowsCfgW-1:0];
          CFG_COLS:      cols_cfg_q  <= cfg_wdata_i[ColsCfgW-1:0];
          CFG_VIEW_ROWS: vrows_cfg_q <= cfg_wdata_i[RowsCfgW-1:0];
          CFG_VIEW_COLS: vcols_cfg_q <= cfg_wdata_i[ColsCfgW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q     <= mode_e'(mode_i);
      char_q     <= char_code_i;
      rrow_q     <= read_row_i;
      rcol_q     <= read_col_i;
      old_top_q  <= view_top_q;
      old_left_q <= view_left_q;
    end
    was_in_q <= was_in_d;
    scroll_q <= scroll_d;
    res_q    <= res_d;
    if (res_move) begin
      out_q <= res_q;
    end
  end

  ttce_ram #(
    .WIDTH(CharW),
    .DEPTH(Depth)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign cell_char_o  = out_q.cell_char;
  assign cursor_row_o = out_q.cursor_row;
  assign cursor_col_o = out_q.cursor_col;
  assign top_row_o    = out_q.top_row;
  assign left_col_o   = out_q.left_col;
  assign scrolled_o   = out_q.scrolled;
  assign view_moved_o = out_q.view_moved;

  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_wr |-> !res_pend_q)
    else $error("Result written while an earlier result is still pending.");

  a_accept_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_FIT)
    else $error("Accepted transaction did not start processing.");

  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> sweep_addr_q <= sweep_end_q)
    else $error("Blanking pass ran past its last address.");

  a_sweep_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) && (sweep_addr_q == sweep_end_q) |=> state_q == S_IDLE)
    else $error("Blanking pass did not return to idle after its last write.");

endmodule

// ===== sim/text_terminal_cursor_engine_tb.sv =====
module text_terminal_cursor_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttce_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int LongHold = 400;
  localparam int RandomPerPhase = 56;
  localparam int NumSettings = 9;

  localparam logic [7:0] SetRows [NumSettings] = '{8'd32, 8'd4, 8'd1, 8'd0, 8'd63,
                                                   8'd32, 8'd8, 8'd200, 8'd5};
  localparam logic [7:0] SetCols [NumSettings] = '{8'd128, 8'd10, 8'd1, 8'd0, 8'd255,
                                                   8'd128, 8'd20, 8'd77, 8'd40};
  localparam logic [7:0] SetVRows [NumSettings] = '{8'd24, 8'd2, 8'd1, 8'd0, 8'd63,
                                                    8'd32, 8'd3, 8'd130, 8'd9};
  localparam logic [7:0] SetVCols [NumSettings] = '{8'd80, 8'd4, 8'd1, 8'd0, 8'd255,
                                                    8'd16, 8'd7, 8'd9, 8'd60};
  localparam int SendIdle [4] = '{0, 61, 0, 38};
  localparam int RecvStall [4] = '{0, 0, 61, 38};

  class terminal_scoreboard;
    logic [CharW-1:0] cells [DefMaxRows*DefMaxCols];
    int unsigned base, crow, ccol, vtop, vleft;
    int unsigned rows_reg, cols_reg, vrows_reg, vcols_reg;
    result_t cursor_reports_q[$];
    int unsigned fail_count, reports_checked, scroll_count, view_moves, clear_count;

    function new();
      clear_buffer();
      rows_reg = 32'(RowsReset);
      cols_reg = 32'(ColsReset);
      vrows_reg = 32'(VRowsReset);
      vcols_reg = 32'(VColsReset);
    endfunction

    function void clear_buffer();
      foreach (cells[i]) cells[i] = ChSpace;
      base = 0;
      crow = 0;
      ccol = 0;
      vtop = 0;
      vleft = 0;
    endfunction

    function int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cell_at(int unsigned row, int unsigned col);
      return ((base + row) % DefMaxRows) * DefMaxCols + (col % DefMaxCols);
    endfunction

    function bit cursor_in_view(int unsigned vr, int unsigned vc);
      return crow >= vtop && crow < vtop + vr && ccol >= vleft && ccol < vleft + vc;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_ROWS: rows_reg = 32'(val & 8'h3F);
        CFG_COLS: cols_reg = 32'(val);
        CFG_VIEW_ROWS: vrows_reg = 32'(val & 8'h3F);
        CFG_VIEW_COLS: vcols_reg = 32'(val);
        default: ;
      endcase
    endfunction

    function int pending();
      return cursor_reports_q.size();
    endfunction

    function void note_command(mode_e md, logic [CharW-1:0] ch, logic [RowOutW-1:0] rr,
                               logic [ColOutW-1:0] rc);
      int unsigned nr, nc, vr, vc, old_top, old_left;
      bit was_in;
      result_t exp;
      nr = clamp_u(rows_reg, 1, DefMaxRows);
      nc = clamp_u(cols_reg, 1, DefMaxCols);
      vr = clamp_u(vrows_reg, 1, nr);
      vc = clamp_u(vcols_reg, 1, nc);
      old_top = vtop;
      old_left = vleft;
      exp = '0;
      if (crow >= nr) crow = nr - 1;
      if (ccol >= nc) ccol = nc - 1;
      if (vtop > nr - vr) vtop = nr - vr;
      if (vleft > nc - vc) vleft = nc - vc;
      case (md)
        MODE_PUT: begin
          was_in = cursor_in_view(vr, vc);
          if (ch == ChBackspace) begin
            if (ccol > 0) begin
              ccol--;
              cells[cell_at(crow, ccol)] = ChSpace;
            end
          end else if (ch == ChReturn) begin
            ccol = 0;
          end else if (ch == ChLineFeed) begin
            crow++;
          end else begin
            cells[cell_at(crow, ccol)] = ch;
            ccol++;
          end
          if (ccol == nc) begin
            crow++;
            ccol = 0;
          end
          if (crow == nr) begin
            base = (base + 1) % DefMaxRows;
            for (int c = 0; c < DefMaxCols; c++) cells[cell_at(nr - 1, c)] = ChSpace;
            crow = nr - 1;
            exp.scrolled = 1'b1;
            scroll_count++;
          end
          if (was_in && !cursor_in_view(vr, vc)) begin
            if (crow < vtop) vtop = crow;
            else if (crow > vtop + vr - 1) vtop = crow + 1 - vr;
            if (vtop > nr - vr) vtop = nr - vr;
            if (ccol < vleft) vleft = ccol;
            else if (ccol > vleft + vc - 1) vleft = ccol + 1 - vc;
            if (vleft > nc - vc) vleft = nc - vc;
          end
        end
        MODE_READ: begin
          if (rr < nr && rc < nc) exp.cell_char = cells[cell_at(32'(rr), 32'(rc))];
        end
        MODE_CLEAR: begin
          clear_buffer();
          clear_count++;
        end
        default: ;
      endcase
      exp.cursor_row = RowOutW'(crow);
      exp.cursor_col = ColOutW'(ccol);
      exp.top_row = RowOutW'(vtop);
      exp.left_col = ColOutW'(vleft);
      exp.view_moved = (vtop != old_top || vleft != old_left);
      if (exp.view_moved) view_moves++;
      cursor_reports_q.push_back(exp);
    endfunction

    function void check_report(result_t got);
      result_t exp;
      if (cursor_reports_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("[%0t] result with nothing expected: char %02h row %0d col %0d",
                   $realtime, got.cell_char, got.cursor_row, got.cursor_col);
        return;
      end
      exp = cursor_reports_q.pop_front();
      reports_checked++;
      if (got.cell_char !== exp.cell_char || got.cursor_row !== exp.cursor_row ||
          got.cursor_col !== exp.cursor_col || got.top_row !== exp.top_row ||
          got.left_col !== exp.left_col || got.scrolled !== exp.scrolled ||
          got.view_moved !== exp.view_moved) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("[%0t] mismatch on result %0d: expected char %02h cur %0d,%0d view %0d,%0d scr %0b mv %0b",
                   $realtime, reports_checked, exp.cell_char, exp.cursor_row,
                   exp.cursor_col, exp.top_row, exp.left_col, exp.scrolled,
                   exp.view_moved);
          $display("    got char %02h cur %0d,%0d view %0d,%0d scr %0b mv %0b",
                   got.cell_char, got.cursor_row, got.cursor_col,
                   got.top_row, got.left_col, got.scrolled, got.view_moved);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [ModeW-1:0] mode_i;
  logic [CharW-1:0] char_code_i;
  logic [RowOutW-1:0] read_row_i;
  logic [ColOutW-1:0] read_col_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CharW-1:0] cell_char_o;
  logic [RowOutW-1:0] cursor_row_o;
  logic [ColOutW-1:0] cursor_col_o;
  logic [RowOutW-1:0] top_row_o;
  logic [ColOutW-1:0] left_col_o;
  logic scrolled_o;
  logic view_moved_o;

  terminal_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int items_sent = 0;
  int cycles = 0;
  int unsigned cur_nr = DefMaxRows;
  int unsigned cur_nc = DefMaxCols;

  text_terminal_cursor_engine i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .char_code_i,
    .read_row_i,
    .read_col_i,
    .out_valid_o,
    .out_stall_i,
    .cell_char_o,
    .cursor_row_o,
    .cursor_col_o,
    .top_row_o,
    .left_col_o,
    .scrolled_o,
    .view_moved_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_command(mode_e'(mode_i), char_code_i, read_row_i, read_col_i);
      if (out_valid_o && !out_stall_i)
        sb.check_report({cell_char_o, cursor_row_o, cursor_col_o, top_row_o, left_col_o,
                         scrolled_o, view_moved_o});
    end
  end

  task automatic send_item(input mode_e md, input logic [CharW-1:0] ch,
                           input logic [RowOutW-1:0] rr, input logic [ColOutW-1:0] rc);
    int gap;
    gap = 0;
    while (gap < 24 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    char_code_i <= ch;
    read_row_i <= rr;
    read_col_i <= rc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic put_char(input logic [CharW-1:0] ch);
    send_item(MODE_PUT, ch, RowOutW'($urandom_range(31)), ColOutW'($urandom_range(127)));
  endtask

  task automatic read_cell(input logic [RowOutW-1:0] rr, input logic [ColOutW-1:0] rc);
    send_item(MODE_READ, CharW'($urandom_range(255)), rr, rc);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 || in_stall_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int quota);
    int first, r, len;
    first = items_sent;
    while (items_sent - first < quota) begin
      r = $urandom_range(99);
      if (r < 15) begin
        len = $urandom_range(24, 1);
        repeat (len) put_char(CharW'($urandom_range(126, 32)));
        put_char(ChReturn);
        put_char(ChLineFeed);
      end else if (r < 60) begin
        put_char(CharW'($urandom_range(126, 32)));
      end else if (r < 66) begin
        put_char(ChBackspace);
      end else if (r < 70) begin
        put_char(ChReturn);
      end else if (r < 78) begin
        put_char(ChLineFeed);
      end else if (r < 84) begin
        put_char(CharW'($urandom_range(255)));
      end else if (r < 96) begin
        if ($urandom_range(3) != 0)
          read_cell(RowOutW'($urandom_range(cur_nr - 1)), ColOutW'($urandom_range(cur_nc - 1)));
        else
          read_cell(RowOutW'($urandom_range(31)), ColOutW'($urandom_range(127)));
      end else if (r < 98) begin
        send_item(MODE_NONE, CharW'($urandom_range(255)), RowOutW'($urandom_range(31)),
                  ColOutW'($urandom_range(127)));
      end else begin
        send_item(MODE_CLEAR, CharW'($urandom_range(255)), RowOutW'($urandom_range(31)),
                  ColOutW'($urandom_range(127)));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ROWS;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_PUT;
    char_code_i = '0;
    read_row_i = '0;
    read_col_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NumSettings; p++) begin
      send_idle_pct = SendIdle[p % 4];
      recv_stall_pct = RecvStall[p % 4];
      write_reg(CFG_ROWS, SetRows[p]);
      write_reg(CFG_COLS, SetCols[p]);
      write_reg(CFG_VIEW_ROWS, SetVRows[p]);
      write_reg(CFG_VIEW_COLS, SetVCols[p]);
      cfg_we_i <= 1'b0;
      cur_nr = sb.clamp_u(32'(SetRows[p] & 8'h3F), 1, DefMaxRows);
      cur_nc = sb.clamp_u(32'(SetCols[p]), 1, DefMaxCols);
      if (p == 0) begin
        read_cell(5'd0, 7'd0);
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(8'h80);
        put_char(ChBackspace);
        read_cell(5'd0, 7'd3);
        read_cell(5'd0, 7'd2);
        read_cell(5'd0, 7'd1);
        put_char(ChReturn);
        put_char(ChBackspace);
        put_char(ChLineFeed);
        put_char(8'h7F);
        send_item(MODE_NONE, 8'hFF, 5'd31, 7'd127);
        read_cell(5'd31, 7'd127);
        send_item(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
        read_cell(5'd0, 7'd0);
        put_char(8'h5A);
        // Hold the output side off while transactions keep coming, so the block backs up.
        hold_requests++;
        repeat (12) put_char(CharW'($urandom_range(126, 32)));
        wait_drained();
      end
      run_random(RandomPerPhase);
      wait_drained();
    end
    repeat (50) @(posedge clk_i);
    $display("Sent %0d transactions over %0d register settings; %0d results checked.",
             items_sent, NumSettings, sb.reports_checked);
    $display("Saw %0d buffer scrolls, %0d window moves and %0d screen clears.",
             sb.scroll_count, sb.view_moves, sb.clear_count);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived.", sb.pending());
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
